FILE: rtl/core/tbd_pkg.sv
// Shared constants, codes and types of the paper-tape block deframer.
package tbd_pkg;

   localparam int FRAME_W   = 8;
   localparam int GROUP_W   = 6;
   localparam int PARTIAL_W = 12;
   localparam int WORD_W    = 18;
   localparam int KIND_W    = 3;
   localparam int ERR_W     = 3;
   localparam int LEADER_W  = 16;

   // Tape frames with a special meaning.
   localparam logic [FRAME_W-1:0] FRAME_SOH = 8'o201;
   localparam logic [FRAME_W-1:0] FRAME_ETX = 8'o203;
   localparam logic [FRAME_W-1:0] FRAME_DC3 = 8'o223;
   localparam logic [FRAME_W-1:0] FRAME_DEL = 8'o377;

   // Channels that may be punched in the first and in the later frames of a word.
   localparam logic [FRAME_W-1:0] MASK_FIRST = 8'o017;
   localparam logic [FRAME_W-1:0] MASK_REST  = 8'o237;

   // Escaped low seven bits and the values that they stand for.
   localparam logic [6:0] ESC_A = 7'o174;
   localparam logic [6:0] ESC_B = 7'o175;
   localparam logic [6:0] ESC_C = 7'o176;
   localparam logic [6:0] ESC_D = 7'o177;
   localparam logic [6:0] SUB_A = 7'o005;
   localparam logic [6:0] SUB_B = 7'o012;
   localparam logic [6:0] SUB_C = 7'o021;
   localparam logic [6:0] SUB_D = 7'o023;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_DATA  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GOOD  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EOT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_EOF_IN_BLOCK = 3'd0;
   localparam logic [ERR_W-1:0] ERR_NO_START     = 3'd1;
   localparam logic [ERR_W-1:0] ERR_STRAY_PUNCH  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_STRAY_DC3    = 3'd3;
   localparam logic [ERR_W-1:0] ERR_NO_DEL       = 3'd4;
   localparam logic [ERR_W-1:0] ERR_SUM_NONZERO  = 3'd5;

   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic               bad;
   } group_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [WORD_W-1:0]   word;
      logic [ERR_W-1:0]    error_code;
      logic [LEADER_W-1:0] leader_count;
   } result_type;

   typedef struct packed {
      logic       emit;
      result_type res;
   } step_type;

endpackage

FILE: rtl/core/tbd_if.sv
// Request and response channel interfaces of the deframer.
interface tbd_req_if;
   logic                       valid;
   logic                       ready;
   logic [tbd_pkg::FRAME_W-1:0] frame;
   logic                       end_of_input;

   modport source (output valid, output frame, output end_of_input, input ready);
   modport sink   (input valid, input frame, input end_of_input, output ready);
endinterface

interface tbd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tbd_pkg::KIND_W-1:0]   kind;
   logic [tbd_pkg::WORD_W-1:0]   word;
   logic [tbd_pkg::ERR_W-1:0]    error_code;
   logic [tbd_pkg::LEADER_W-1:0] leader_count;

   modport source (output valid, output kind, output word, output error_code,
                   output leader_count, input ready);
   modport sink   (input valid, input kind, input word, input error_code,
                   input leader_count, output ready);
endinterface

FILE: rtl/core/tbd_group_decode.sv
// Decodes one tape frame into a 6-bit group with its channel check.
module tbd_group_decode (
   input  logic [tbd_pkg::FRAME_W-1:0] frame,
   input  logic                        is_first,
   output tbd_pkg::group_type          dec
);
   import tbd_pkg::*;

   logic [6:0]         low7;
   logic               escaped;
   logic [FRAME_W-1:0] mask;

   always_comb begin
      escaped = 1'b1;
      case (frame[6:0])
         ESC_A: low7 = SUB_A;
         ESC_B: low7 = SUB_B;
         ESC_C: low7 = SUB_C;
         ESC_D: low7 = SUB_D;
         default: begin
            low7    = frame[6:0];
            escaped = 1'b0;
         end
      endcase
   end

   assign mask      = is_first ? MASK_FIRST : MASK_REST;
   // Channel 8 becomes the top bit of the group.
   assign dec.group = {frame[7], low7[4:0]};
   assign dec.bad   = !escaped && ((frame & ~mask) != '0);

endmodule

FILE: rtl/core/tbd_block_fsm.sv
// Block state machine: leader count, word assembly, checksum and results.
module tbd_block_fsm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [tbd_pkg::FRAME_W-1:0] frame,
   input  logic                        end_of_input,
   output tbd_pkg::step_type           out
);
   import tbd_pkg::*;

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_ETX1 = 3'd1;
   localparam logic [2:0] PH_ETX2 = 3'd2;
   localparam logic [2:0] PH_W0   = 3'd3;
   localparam logic [2:0] PH_W1   = 3'd4;
   localparam logic [2:0] PH_W2   = 3'd5;
   localparam logic [2:0] PH_FIN  = 3'd6;

   logic [2:0]           phase_ff, phase_in;
   logic [PARTIAL_W-1:0] partial_ff, partial_in;
   logic [WORD_W-1:0]    check_ff, check_in;
   logic [LEADER_W-1:0]  tally_ff, tally_in;
   logic [WORD_W-1:0]    full_word;
   group_type            dec;

   tbd_group_decode u_decode (
      .frame    (frame),
      .is_first (phase_ff == PH_W0),
      .dec      (dec)
   );

   assign full_word = {partial_ff, dec.group};

   always_comb begin
      phase_in   = phase_ff;
      partial_in = partial_ff;
      check_in   = check_ff;
      tally_in   = tally_ff;
      out.emit              = 1'b0;
      out.res.kind          = KIND_DATA;
      out.res.word          = '0;
      out.res.error_code    = ERR_EOF_IN_BLOCK;
      out.res.leader_count  = tally_ff;

      if (end_of_input) begin
         out.emit     = 1'b1;
         out.res.kind = (phase_ff == PH_HUNT) ? KIND_END : KIND_ERROR;
      end else begin
         case (phase_ff)
            PH_ETX1: begin
               if (frame == FRAME_DC3) begin
                  phase_in = PH_ETX2;
               end else begin
                  out.emit           = 1'b1;
                  out.res.kind       = KIND_ERROR;
                  out.res.error_code = ERR_NO_START;
               end
            end
            PH_ETX2: begin
               out.emit = 1'b1;
               if (frame == FRAME_DEL) begin
                  out.res.kind = KIND_EOT;
               end else begin
                  out.res.kind       = KIND_ERROR;
                  out.res.error_code = ERR_NO_START;
               end
            end
            PH_W0: begin
               if (frame == FRAME_DC3) begin
                  phase_in = PH_FIN;
               end else if (dec.bad) begin
                  out.emit           = 1'b1;
                  out.res.kind       = KIND_ERROR;
                  out.res.error_code = ERR_STRAY_PUNCH;
               end else begin
                  partial_in = {{(PARTIAL_W-GROUP_W){1'b0}}, dec.group};
                  phase_in   = PH_W1;
               end
            end
            PH_W1, PH_W2: begin
               if (frame == FRAME_DC3) begin
                  out.emit           = 1'b1;
                  out.res.kind       = KIND_ERROR;
                  out.res.error_code = ERR_STRAY_DC3;
               end else if (dec.bad) begin
                  out.emit           = 1'b1;
                  out.res.kind       = KIND_ERROR;
                  out.res.error_code = ERR_STRAY_PUNCH;
               end else if (phase_ff == PH_W1) begin
                  partial_in = {partial_ff[GROUP_W-1:0], dec.group};
                  phase_in   = PH_W2;
               end else begin
                  check_in     = check_ff ^ full_word;
                  phase_in     = PH_W0;
                  out.emit     = 1'b1;
                  out.res.word = full_word;
               end
            end
            PH_FIN: begin
               out.emit = 1'b1;
               if (frame != FRAME_DEL) begin
                  out.res.kind       = KIND_ERROR;
                  out.res.error_code = ERR_NO_DEL;
               end else if (check_ff != '0) begin
                  out.res.kind       = KIND_ERROR;
                  out.res.error_code = ERR_SUM_NONZERO;
               end else begin
                  out.res.kind = KIND_GOOD;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (frame == '0) begin
                  if (tally_ff != '1) begin
                     tally_in = tally_ff + 16'd1;
                  end
               end else if (frame == FRAME_SOH) begin
                  check_in   = '0;
                  partial_in = '0;
                  phase_in   = PH_W0;
               end else if (frame == FRAME_ETX) begin
                  phase_in = PH_ETX1;
               end else begin
                  out.emit           = 1'b1;
                  out.res.kind       = KIND_ERROR;
                  out.res.error_code = ERR_NO_START;
               end
            end
         endcase
      end

      // Any result other than a data word closes the block.
      if (out.emit && out.res.kind != KIND_DATA) begin
         phase_in = PH_HUNT;
         tally_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         partial_ff <= '0;
         check_ff   <= '0;
         tally_ff   <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
         check_ff   <= check_in;
         tally_ff   <= tally_in;
      end
   end

`ifndef SYNTHESIS
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      step && out.emit && out.res.kind != KIND_DATA |=>
         phase_ff == PH_HUNT && tally_ff == '0)
      else $error("block did not return to leader hunting after a result");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      step && !end_of_input && phase_ff == PH_HUNT && frame == FRAME_SOH |=>
         phase_ff == PH_W0 && check_ff == '0)
      else $error("start of block did not clear the checksum");

   a_word_folds: assert property (@(posedge clock) disable iff (reset)
      step && out.emit && out.res.kind == KIND_DATA |=>
         phase_ff == PH_W0 && check_ff == $past(check_ff ^ out.res.word))
      else $error("data word was not folded into the checksum");
`endif

endmodule

FILE: rtl/core/tape_block_deframer_top.sv
// Top level of the paper-tape block deframer with its request and response registers.
// A request accepted into the request register is decoded while it is held there, and its
// response, if it has one, enters the response register as the request moves on.
// Throughput: one request per cycle; the request register refills in the same cycle that
// it hands its frame to the state machine, and only a held response can stall it.
// Reset is synchronous and active high: both registers empty, leader hunting, all counts zero.
module tape_block_deframer_top (
   input  logic      clock,
   input  logic      reset,
   tbd_req_if.sink   req,
   tbd_rsp_if.source rsp
);
   import tbd_pkg::*;

   // Request register: one frame waiting for the state machine.
   logic               in_valid_ff;
   logic [FRAME_W-1:0] in_frame_ff;
   logic               in_eoi_ff;

   // Response register.
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   step_type fsm_out;
   logic     step;

   // The held request moves on when it gives no response, or when the response register
   // is empty or is being emptied in this cycle.
   assign step = in_valid_ff && (!fsm_out.emit || !rsp_valid_ff || rsp.ready);

   // A new request may enter whenever the request register is empty or moves on.
   assign req.ready = !in_valid_ff || step;

   tbd_block_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .frame        (in_frame_ff),
      .end_of_input (in_eoi_ff),
      .out          (fsm_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_frame_ff <= req.frame;
         in_eoi_ff   <= req.end_of_input;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && fsm_out.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && fsm_out.emit) begin
         rsp_data_ff <= fsm_out.res;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = rsp_data_ff.kind;
   assign rsp.word         = rsp_data_ff.word;
   assign rsp.error_code   = rsp_data_ff.error_code;
   assign rsp.leader_count = rsp_data_ff.leader_count;

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |-> rsp_valid_ff && !rsp.ready && fsm_out.emit)
      else $error("request held although the response side was free");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      step && fsm_out.emit |=> rsp_valid_ff)
      else $error("response was lost on its way to the response register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending response was overwritten");
`endif

endmodule
